// ----- hw/rtl/cdt_pkg.sv -----
package cdt_pkg;

  // Event codes carried on the input channel.
  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_BUTTON     = 4'd1,
    OP_LEFT       = 4'd2,
    OP_RIGHT      = 4'd3,
    OP_UP         = 4'd4,
    OP_DOWN       = 4'd5,
    OP_START_STOP = 4'd6,
    OP_RESET      = 4'd7,
    OP_ENTER_SET  = 4'd8
  } op_t;

  // Edit unit codes.
  localparam logic [1:0] UNIT_SEC  = 2'd0;
  localparam logic [1:0] UNIT_MIN  = 2'd1;
  localparam logic [1:0] UNIT_HOUR = 2'd2;

  localparam int unsigned TimeW = 19;

  // Time constants in seconds.
  localparam logic [TimeW-1:0] SEC_PER_MIN  = 19'd60;
  localparam logic [TimeW-1:0] SEC_PER_HR   = 19'd3600;
  localparam logic [TimeW-1:0] WRAP_SECONDS = 19'd360000;  // 100 hours
  localparam logic [TimeW-1:0] DOWN_HR_ADD  = 19'd356400;  // 99 hours
  localparam logic [TimeW-1:0] PRESET_RESET = 19'd90;
  localparam logic [TimeW-1:0] COUNT_RESET  = 19'd2;

  // One input event.
  typedef struct packed {
    logic [3:0] operation;
    logic [3:0] step_amount;
    logic [7:0] elapsed;
  } item_t;

  // One result, the timer state after an event plus the two pulses.
  typedef struct packed {
    logic             menu_request;
    logic             buzzer_start;
    logic [1:0]       edit_unit;
    logic             in_set_mode;
    logic             is_running;
    logic [TimeW-1:0] preset_seconds;
    logic [TimeW-1:0] remaining_seconds;
  } res_t;

endpackage

// ----- hw/rtl/countdown_timer_with_setter.sv -----
// Channel  Direction  tuser                 tdata
// in_      slave      [3:0] operation       [3:0] step_amount, [11:4] elapsed
// out_     master     (none)                [18:0] remaining_seconds, [37:19] preset_seconds,
//                                           [38] is_running, [39] in_set_mode,
//                                           [41:40] edit_unit, [42] buzzer_start,
//                                           [43] menu_request
//
// One event per cycle sustained while the output is not stalled.
// The event is held in an input register, then one pass of logic updates the timer state
// and loads the output register in the same cycle.
// Reset sets the preset to 90 s, the countdown to 2 s, stopped, not editing, unit seconds.
// A stalled output holds its result; the input register takes one more request and then
// in_tready stays low until the result is taken.
module countdown_timer_with_setter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // step_amount, elapsed, zero pad
  input  logic [3:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // remaining_seconds, preset_seconds, is_running,
                                  // in_set_mode, edit_unit, buzzer_start,
                                  // menu_request, zero pad
);

  logic           in_vld_r;
  cdt_pkg::item_t in_item_r;
  logic           out_vld_r;
  cdt_pkg::res_t  out_res_r;
  cdt_pkg::res_t  res;
  logic           advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.operation   <= in_tuser;
      in_item_r.step_amount <= in_tdata[3:0];
      in_item_r.elapsed     <= in_tdata[11:4];
    end
  end

  cdt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .res   (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_res_r};

endmodule

// ----- hw/rtl/cdt_core.sv -----
module cdt_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  cdt_pkg::item_t item,
  output cdt_pkg::res_t  res
);

  logic [cdt_pkg::TimeW-1:0] preset_r, preset_nxt;
  logic [cdt_pkg::TimeW-1:0] count_r, count_nxt;
  logic                      run_r, run_nxt;
  logic                      edit_r, edit_nxt;
  logic [1:0]                unit_r, unit_nxt;
  logic                      buzz, menu;

  logic [cdt_pkg::TimeW-1:0] amt_ext;
  logic [cdt_pkg::TimeW-1:0] delta;
  logic [cdt_pkg::TimeW-1:0] down_add;
  logic [cdt_pkg::TimeW-1:0] up_sum;
  logic [cdt_pkg::TimeW-1:0] down_base;
  logic [cdt_pkg::TimeW-1:0] el_ext;

  assign amt_ext = {15'd0, item.step_amount};
  assign el_ext  = {11'd0, item.elapsed};

  // Step size and the borrow added when a down edit would go below zero.
  // Unit code three is never reached; it behaves as seconds.
  always_comb begin
    case (unit_r)
      cdt_pkg::UNIT_MIN: begin
        delta    = cdt_pkg::TimeW'(amt_ext * cdt_pkg::SEC_PER_MIN);
        down_add = cdt_pkg::SEC_PER_HR;
      end
      cdt_pkg::UNIT_HOUR: begin
        delta    = cdt_pkg::TimeW'(amt_ext * cdt_pkg::SEC_PER_HR);
        down_add = cdt_pkg::DOWN_HR_ADD;
      end
      default: begin
        delta    = amt_ext;
        down_add = cdt_pkg::SEC_PER_MIN;
      end
    endcase
  end

  // The preset stays below 100 hours, so the sums fit in 19 bits.
  assign up_sum    = preset_r + delta;
  assign down_base = (delta > preset_r) ? preset_r + down_add : preset_r;

  // Next state for one event.
  always_comb begin
    preset_nxt = preset_r;
    count_nxt  = count_r;
    run_nxt    = run_r;
    edit_nxt   = edit_r;
    unit_nxt   = unit_r;
    buzz       = 1'b0;
    menu       = 1'b0;
    unique case (cdt_pkg::op_t'(item.operation))
      cdt_pkg::OP_TICK: begin
        if (run_r) begin
          if (count_r > el_ext) begin
            count_nxt = count_r - el_ext;
          end else begin
            count_nxt = '0;
            run_nxt   = 1'b0;
            buzz      = 1'b1;
          end
        end
      end
      cdt_pkg::OP_BUTTON: begin
        if (edit_r) begin
          edit_nxt  = 1'b0;
          count_nxt = preset_r;
        end else begin
          menu = 1'b1;
        end
      end
      cdt_pkg::OP_LEFT: begin
        if (edit_r) begin
          unit_nxt = (unit_r == cdt_pkg::UNIT_HOUR) ? cdt_pkg::UNIT_SEC :
                     (unit_r == cdt_pkg::UNIT_MIN)  ? cdt_pkg::UNIT_HOUR :
                                                      cdt_pkg::UNIT_MIN;
        end
      end
      cdt_pkg::OP_RIGHT: begin
        if (edit_r) begin
          unit_nxt = (unit_r == cdt_pkg::UNIT_HOUR) ? cdt_pkg::UNIT_MIN :
                     (unit_r == cdt_pkg::UNIT_MIN)  ? cdt_pkg::UNIT_SEC :
                                                      cdt_pkg::UNIT_HOUR;
        end
      end
      cdt_pkg::OP_UP: begin
        if (edit_r) begin
          preset_nxt = (up_sum >= cdt_pkg::WRAP_SECONDS) ?
                       up_sum - cdt_pkg::WRAP_SECONDS : up_sum;
        end
      end
      cdt_pkg::OP_DOWN: begin
        if (edit_r) begin
          preset_nxt = down_base - delta;
        end
      end
      cdt_pkg::OP_START_STOP: begin
        if (!edit_r) begin
          run_nxt = ~run_r;
        end
      end
      cdt_pkg::OP_RESET: begin
        count_nxt = preset_r;
        run_nxt   = 1'b0;
      end
      cdt_pkg::OP_ENTER_SET: begin
        run_nxt  = 1'b0;
        edit_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Timer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= cdt_pkg::PRESET_RESET;
      count_r  <= cdt_pkg::COUNT_RESET;
      run_r    <= 1'b0;
      edit_r   <= 1'b0;
      unit_r   <= cdt_pkg::UNIT_SEC;
    end else if (step) begin
      preset_r <= preset_nxt;
      count_r  <= count_nxt;
      run_r    <= run_nxt;
      edit_r   <= edit_nxt;
      unit_r   <= unit_nxt;
    end
  end

  // The result shows the state after the event.
  always_comb begin
    res.remaining_seconds = count_nxt;
    res.preset_seconds    = preset_nxt;
    res.is_running        = run_nxt;
    res.in_set_mode       = edit_nxt;
    res.edit_unit         = unit_nxt;
    res.buzzer_start      = buzz;
    res.menu_request      = menu;
  end

endmodule

// ----- hw/rtl/cdt_checker.sv -----
module cdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Both times stay below 100 hours.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[18:0] < 19'd360000) && (out_tdata[37:19] < 19'd360000))
    else $error("time value out of range");

  // The timer never runs while the preset is being edited.
  a_run_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[38] && out_tdata[39]))
    else $error("running in set mode");

  // The buzzer starts only as the countdown stops at zero.
  a_buzz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[42] |-> !out_tdata[38] && (out_tdata[18:0] == 19'd0))
    else $error("buzzer pulse with timer not stopped at zero");

  // A menu request comes only from outside set mode, and the unit code three never shows.
  a_menu_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[43] && out_tdata[39]) && (out_tdata[41:40] != 2'd3))
    else $error("menu request in set mode or bad edit unit");

endmodule

bind countdown_timer_with_setter cdt_checker u_cdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
